@@ rtl/codec_indexed_register_file_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the indexed register file block.
// Checks are compiled for simulation and vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CODEC_INDEXED_REGISTER_FILE_TOP_MACROS_SVH
`define CODEC_INDEXED_REGISTER_FILE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Concurrent assertion on an explicit clock and active-low reset.
`define CIRF_ASSERT_CLK(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error("cirf assertion failed");
// Concurrent assertion on the block clock clk and reset rst_n.
`define CIRF_ASSERT(lbl, prop) `CIRF_ASSERT_CLK(lbl, clk, rst_n, prop)
`else
`define CIRF_ASSERT_CLK(lbl, clk_s, rst_s, prop)
`define CIRF_ASSERT(lbl, prop)
`endif

`endif

@@ rtl/cirf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cirf_pkg
// Shared codes, reset values and types of the indexed register file block.
// ----------------------------------------------------------------------------
package cirf_pkg;

  // Item kinds.
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_IRQ   = 2'd2;

  // Bus addresses.
  localparam logic [2:0] ADDR_CFG_LO = 3'd0;
  localparam logic [2:0] ADDR_CFG_HI = 3'd3;
  localparam logic [2:0] ADDR_INDEX  = 3'd4;
  localparam logic [2:0] ADDR_DATA   = 3'd5;
  localparam logic [2:0] ADDR_STATUS = 3'd6;

  // Indirect register numbers with side effects.
  localparam logic [3:0] REG_RATE     = 4'd8;
  localparam logic [3:0] REG_CAPTURE  = 4'd9;
  localparam logic [3:0] REG_IRQ_CTRL = 4'd10;
  localparam logic [3:0] REG_RDONLY   = 4'd12;
  localparam logic [3:0] REG_COUNT_HI = 4'd14;
  localparam logic [3:0] REG_COUNT_LO = 4'd15;

  localparam int unsigned REG_DEPTH = 16;

  // Reset values.
  localparam logic [7:0] STATUS_RESET = 8'hCC;
  localparam logic [7:0] RD_IDLE      = 8'hFF;
  localparam logic [7:0] REG_INIT [REG_DEPTH] = '{
    8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
    8'h00, 8'h08, 8'h00, 8'h00, 8'h0A, 8'h00, 8'h00, 8'h00
  };

  // Sample rate divider by the code in bits 3..1 of register 8.
  localparam logic [5:0] DIV_TABLE [8] = '{
    6'd48, 6'd24, 6'd14, 6'd12, 6'd7, 6'd6, 6'd8, 6'd40
  };

  // Access to the indirect register memory.
  typedef struct packed {
    logic       rd_en;
    logic [3:0] rd_addr;
    logic       wr_en;
    logic [3:0] wr_addr;
    logic [7:0] wr_data;
  } cirf_mem_req_t;

endpackage

@@ rtl/cirf_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cirf_in_if
// Input channel: one bus read, bus write or interrupt event per item.
// ----------------------------------------------------------------------------
interface cirf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [2:0] addr;
  logic [7:0] wdata;

  modport source (output valid, output mode, output addr, output wdata, input ready);
  modport sink (input valid, input mode, input addr, input wdata, output ready);
endinterface

@@ rtl/cirf_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cirf_out_if
// Result channel: read data, interrupt flags and current codec settings.
// ----------------------------------------------------------------------------
interface cirf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        irq_raise;
  logic        irq_clear;
  logic        playback_on;
  logic        capture_on;
  logic        capture_start;
  logic        capture_stop;
  logic [5:0]  divider;
  logic [15:0] sample_count;

  modport source (
    output valid, output read_data, output irq_raise, output irq_clear,
    output playback_on, output capture_on, output capture_start,
    output capture_stop, output divider, output sample_count, input ready
  );
  modport sink (
    input valid, input read_data, input irq_raise, input irq_clear,
    input playback_on, input capture_on, input capture_start,
    input capture_stop, input divider, input sample_count, output ready
  );
endinterface

@@ rtl/cirf_regmem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cirf_regmem
// Sixteen indirect registers in a synchronous memory with registered reads.
// Entries not yet written read as their power-on defaults.
// ----------------------------------------------------------------------------
module cirf_regmem (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cirf_pkg::cirf_mem_req_t mem_req,
  output logic [7:0]             rd_data
);
  import cirf_pkg::*;

  logic [7:0]           mem [REG_DEPTH];
  logic [REG_DEPTH-1:0] vld_r;
  logic [REG_DEPTH-1:0] vld_nxt;
  logic [7:0]           q_r;
  logic                 q_vld_r;
  logic [3:0]           q_idx_r;

  // Memory array: one write and one read port, registered read data.
  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      mem[mem_req.wr_addr] <= mem_req.wr_data;
    end
    if (mem_req.rd_en) begin
      q_r     <= mem[mem_req.rd_addr];
      q_idx_r <= mem_req.rd_addr;
    end
  end

  // Written flags per entry; reset returns every entry to its default.
  always_comb begin
    vld_nxt = vld_r;
    if (mem_req.wr_en) begin
      vld_nxt[mem_req.wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (mem_req.rd_en) begin
        q_vld_r <= vld_r[mem_req.rd_addr];
      end
    end
  end

  // Substitute the default for an entry that was never written.
  assign rd_data = q_vld_r ? q_r : REG_INIT[q_idx_r];

endmodule

@@ rtl/cirf_ctrl.sv @@
`timescale 1ns / 1ps
`include "codec_indexed_register_file_top_macros.svh"
// ----------------------------------------------------------------------------
// cirf_ctrl
// Host access sequencer: takes an item, reads the indirect register memory,
// then updates the direct registers, writes back and registers the result.
// ----------------------------------------------------------------------------
module cirf_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  cirf_in_if.sink                 in_if,
  cirf_out_if.source              out_if,
  output cirf_pkg::cirf_mem_req_t mem_req,
  input  logic [7:0]              mem_rd_data
);
  import cirf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t      state_r, state_nxt;
  logic [1:0]  mode_r;
  logic [2:0]  addr_r;
  logic [7:0]  wdata_r;

  logic [3:0]  index_r, index_nxt;
  logic        trd_r, trd_nxt;
  logic        mce_r, mce_nxt;
  logic [7:0]  cfg_r, cfg_nxt;
  logic [7:0]  status_r, status_nxt;
  logic        play_r, play_nxt;
  logic        cap_r, cap_nxt;
  logic [5:0]  div_r, div_nxt;
  logic [15:0] count_r, count_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  rd_r, rd_nxt;
  logic        raise_r, raise_nxt;
  logic        clr_r, clr_nxt;
  logic        start_r, start_nxt;
  logic        stop_r, stop_nxt;

  logic        accept;
  logic        exec_done;
  logic        cap_new;

  assign in_if.ready = (state_r == ST_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign exec_done   = (state_r == ST_EXEC) && (!out_valid_r || out_if.ready);
  assign cap_new     = wdata_r[1] && !wdata_r[7];

  // Item execution: direct register update, write back and result.
  always_comb begin
    // Memory read on accept: the entry the item will need in ST_EXEC.
    mem_req.rd_en = accept;
    case (in_if.mode)
      MODE_IRQ:   mem_req.rd_addr = REG_IRQ_CTRL;
      MODE_WRITE: mem_req.rd_addr = REG_COUNT_LO;
      default:    mem_req.rd_addr = index_r;
    endcase
    index_nxt       = index_r;
    trd_nxt         = trd_r;
    mce_nxt         = mce_r;
    cfg_nxt         = cfg_r;
    status_nxt      = status_r;
    play_nxt        = play_r;
    cap_nxt         = cap_r;
    div_nxt         = div_r;
    count_nxt       = count_r;
    rd_nxt          = RD_IDLE;
    raise_nxt       = 1'b0;
    clr_nxt         = 1'b0;
    start_nxt       = 1'b0;
    stop_nxt        = 1'b0;
    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = index_r;
    mem_req.wr_data = wdata_r;
    if (exec_done) begin
      case (mode_r)
        MODE_READ: begin
          case (addr_r) inside
            [ADDR_CFG_LO:ADDR_CFG_HI]: rd_nxt = {1'b0, cfg_r[6], 3'b000, 1'b1, 2'b00};
            ADDR_INDEX:  rd_nxt = {1'b0, mce_r, trd_r, 1'b0, index_r};
            ADDR_DATA:   rd_nxt = mem_rd_data;
            ADDR_STATUS: rd_nxt = status_r;
            default:     rd_nxt = RD_IDLE;
          endcase
        end
        MODE_WRITE: begin
          case (addr_r) inside
            [ADDR_CFG_LO:ADDR_CFG_HI]: cfg_nxt = wdata_r;
            ADDR_INDEX: begin
              index_nxt = wdata_r[3:0];
              trd_nxt   = wdata_r[5];
              mce_nxt   = wdata_r[6];
            end
            ADDR_DATA: begin
              // Register 12 is read-only; every other write is stored.
              mem_req.wr_en = (index_r != REG_RDONLY);
              case (index_r)
                REG_RATE: div_nxt = DIV_TABLE[wdata_r[3:1]];
                REG_CAPTURE: begin
                  // Playback needs bit 0 set and bit 6 clear; capture bit 1 and bit 7.
                  play_nxt  = wdata_r[0] && !wdata_r[6];
                  cap_nxt   = cap_new;
                  start_nxt = cap_new && !cap_r;
                  stop_nxt  = !cap_new && cap_r;
                end
                REG_COUNT_HI: count_nxt = {wdata_r, mem_rd_data};
                default: ;
              endcase
            end
            ADDR_STATUS: begin
              status_nxt = {status_r[7:1], 1'b0};
              clr_nxt    = 1'b1;
            end
            default: ;
          endcase
        end
        MODE_IRQ: begin
          status_nxt = {status_r[7:1], 1'b1};
          raise_nxt  = mem_rd_data[1];
        end
        default: ;
      endcase
    end
  end

  // Sequencer and output valid.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (exec_done) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and architectural registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      index_r     <= '0;
      trd_r       <= 1'b0;
      mce_r       <= 1'b1;
      cfg_r       <= '0;
      status_r    <= STATUS_RESET;
      play_r      <= 1'b0;
      cap_r       <= 1'b0;
      div_r       <= DIV_TABLE[0];
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      index_r     <= index_nxt;
      trd_r       <= trd_nxt;
      mce_r       <= mce_nxt;
      cfg_r       <= cfg_nxt;
      status_r    <= status_nxt;
      play_r      <= play_nxt;
      cap_r       <= cap_nxt;
      div_r       <= div_nxt;
      count_r     <= count_nxt;
    end
  end

  // Item capture and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_if.mode;
      addr_r  <= in_if.addr;
      wdata_r <= in_if.wdata;
    end
    if (exec_done) begin
      rd_r    <= rd_nxt;
      raise_r <= raise_nxt;
      clr_r   <= clr_nxt;
      start_r <= start_nxt;
      stop_r  <= stop_nxt;
    end
  end

  // Settings change only when a result is loaded, so they drive the port directly.
  assign out_if.valid         = out_valid_r;
  assign out_if.read_data     = rd_r;
  assign out_if.irq_raise     = raise_r;
  assign out_if.irq_clear     = clr_r;
  assign out_if.playback_on   = play_r;
  assign out_if.capture_on    = cap_r;
  assign out_if.capture_start = start_r;
  assign out_if.capture_stop  = stop_r;
  assign out_if.divider       = div_r;
  assign out_if.sample_count  = count_r;

  `CIRF_ASSERT(a_accept_exec, accept |=> state_r == ST_EXEC)
  `CIRF_ASSERT(a_no_ro_write, mem_req.wr_en |-> state_r == ST_EXEC && index_r != REG_RDONLY)
  `CIRF_ASSERT(a_start_stop_excl, out_valid_r |-> !(start_r && stop_r))
  `CIRF_ASSERT(a_start_cap_on, out_valid_r && start_r |-> cap_r)
  `CIRF_ASSERT(a_read_flags, out_valid_r && rd_r != RD_IDLE |-> !raise_r && !clr_r)

endmodule

@@ rtl/codec_indexed_register_file_top.sv @@
`timescale 1ns / 1ps
// Each item first reads the indirect register memory synchronously, then it
// modifies, writes back and registers the result. A new item is taken once
// the previous one has finished; a result that the sink has not yet taken
// holds the next item in its execute step. After reset all sixteen indirect
// registers read as their power-on defaults at once.
// ----------------------------------------------------------------------------
// codec_indexed_register_file_top
// Audio codec host interface with index, config, status and sixteen indirect
// registers, rate divider, capture control and transfer count.
// ----------------------------------------------------------------------------
module codec_indexed_register_file_top (
  input  logic       clk,
  input  logic       rst_n,
  cirf_in_if.sink    in_if,
  cirf_out_if.source out_if
);
  import cirf_pkg::*;

  cirf_mem_req_t mem_req;
  logic [7:0]    mem_rd_data;

  // Access sequencer and direct registers.
  cirf_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_if),
    .out_if      (out_if),
    .mem_req     (mem_req),
    .mem_rd_data (mem_rd_data)
  );

  // Indirect register memory.
  cirf_regmem u_regmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .mem_req (mem_req),
    .rd_data (mem_rd_data)
  );

endmodule

@@ tb/codec_indexed_register_file_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// codec_indexed_register_file_top_tb
// Drives bus reads, bus writes and interrupt events into the codec register
// file and checks every result item against an internal model of the index,
// config, status and indirect registers and their side effects. Both channels
// idle at random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module codec_indexed_register_file_top_tb;
  import cirf_pkg::*;

  // Codes and masks that the package does not name.
  localparam logic [1:0] MODE_NOP    = 2'd3;
  localparam logic [2:0] ADDR_UNUSED = 3'd7;
  localparam logic [7:0] VERSION_ID  = 8'h04;
  localparam logic [7:0] CFG_SEEN    = 8'h40;
  localparam logic [7:0] PLAY_MASK   = 8'h41;
  localparam logic [7:0] PLAY_ON     = 8'h01;
  localparam logic [7:0] CAP_MASK    = 8'h82;
  localparam logic [7:0] CAP_ON      = 8'h02;

  // Power-on register contents and divider decode, kept apart from the RTL.
  localparam logic [7:0] REGS_AT_RESET [16] = '{
    8'h00, 8'h00, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80,
    8'h00, 8'h08, 8'h00, 8'h00, 8'h0a, 8'h00, 8'h00, 8'h00
  };
  localparam logic [5:0] RATE_DIVS [8] = '{
    6'd48, 6'd24, 6'd14, 6'd12, 6'd7, 6'd6, 6'd8, 6'd40
  };
  localparam logic [3:0] SIDE_EFFECT_REGS [6] = '{
    REG_RATE, REG_CAPTURE, REG_IRQ_CTRL, REG_RDONLY, REG_COUNT_HI, REG_COUNT_LO
  };

  localparam int unsigned HOLD_CYCLES    = 200;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 10;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        irq_raise;
    logic        irq_clear;
    logic        playback_on;
    logic        capture_on;
    logic        capture_start;
    logic        capture_stop;
    logic [5:0]  divider;
    logic [15:0] sample_count;
  } codec_result_t;

  logic clk;
  logic rst_n;

  cirf_in_if  in_bus ();
  cirf_out_if out_bus ();

  codec_indexed_register_file_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus)
  );

  // Model state of the codec registers.
  logic [3:0]  cur_index;
  logic        cur_trd;
  logic        cur_mce;
  logic [7:0]  cfg_byte;
  logic [7:0]  stat_byte;
  logic [7:0]  codec_regs [16];
  logic        play_en;
  logic        cap_en;
  logic [5:0]  rate_div;
  logic [15:0] xfer_count;

  codec_result_t pending_results [$];
  int unsigned   mismatch_count;

  // Idling controls: steady is shared by the sender and the receiver, long_hold is read by the receiver only.
  bit steady;
  bit long_hold;

  // Clock.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Returns an idle length: mostly none, sometimes short, rarely long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [3:0] pick_reg();
    if ($urandom_range(0, 1) == 0) return SIDE_EFFECT_REGS[3'($urandom_range(0, 5))];
    return 4'($urandom_range(0, 15));
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t: MISMATCH %s", $time, what);
    mismatch_count++;
  endtask

  // Applies one bus access to the model and returns the result it causes.
  function automatic codec_result_t predict_access(logic [1:0] mode, logic [2:0] addr,
                                                   logic [7:0] wdata);
    codec_result_t res;
    logic cap_next;
    res = '0;
    res.read_data = RD_IDLE;
    case (mode)
      MODE_READ: begin
        if (addr <= ADDR_CFG_HI) res.read_data = VERSION_ID | (cfg_byte & CFG_SEEN);
        else if (addr == ADDR_INDEX) res.read_data = {1'b0, cur_mce, cur_trd, 1'b0, cur_index};
        else if (addr == ADDR_DATA) res.read_data = codec_regs[cur_index];
        else if (addr == ADDR_STATUS) res.read_data = stat_byte;
      end
      MODE_WRITE: begin
        if (addr <= ADDR_CFG_HI) begin
          cfg_byte = wdata;
        end else if (addr == ADDR_INDEX) begin
          cur_index = wdata[3:0];
          cur_trd = wdata[5];
          cur_mce = wdata[6];
        end else if (addr == ADDR_DATA) begin
          // Indirect write; most registers just store the byte.
          case (cur_index)
            REG_RATE: begin
              rate_div = RATE_DIVS[wdata[3:1]];
              codec_regs[cur_index] = wdata;
            end
            REG_CAPTURE: begin
              play_en = (wdata & PLAY_MASK) == PLAY_ON;
              cap_next = (wdata & CAP_MASK) == CAP_ON;
              res.capture_start = cap_next && !cap_en;
              res.capture_stop = !cap_next && cap_en;
              cap_en = cap_next;
              codec_regs[cur_index] = wdata;
            end
            REG_RDONLY: ;
            REG_COUNT_HI: begin
              xfer_count = {wdata, codec_regs[REG_COUNT_LO]};
              codec_regs[cur_index] = wdata;
            end
            default: codec_regs[cur_index] = wdata;
          endcase
        end else if (addr == ADDR_STATUS) begin
          stat_byte[0] = 1'b0;
          res.irq_clear = 1'b1;
        end
      end
      MODE_IRQ: begin
        stat_byte[0] = 1'b1;
        res.irq_raise = codec_regs[REG_IRQ_CTRL][1];
      end
      default: ;
    endcase
    res.playback_on = play_en;
    res.capture_on = cap_en;
    res.divider = rate_div;
    res.sample_count = xfer_count;
    return res;
  endfunction

  // Check each result item against the oldest expectation, then record the
  // expectation for an item taken at this edge.
  always @(posedge clk) begin
    codec_result_t got;
    codec_result_t want;
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        got.read_data = out_bus.read_data;
        got.irq_raise = out_bus.irq_raise;
        got.irq_clear = out_bus.irq_clear;
        got.playback_on = out_bus.playback_on;
        got.capture_on = out_bus.capture_on;
        got.capture_start = out_bus.capture_start;
        got.capture_stop = out_bus.capture_stop;
        got.divider = out_bus.divider;
        got.sample_count = out_bus.sample_count;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing pending", got));
        end else begin
          want = pending_results.pop_front();
          if (got.read_data !== want.read_data)
            report_mismatch($sformatf("read_data %h, expected %h", got.read_data,
                                      want.read_data));
          if (got.irq_raise !== want.irq_raise)
            report_mismatch($sformatf("irq_raise %b, expected %b", got.irq_raise,
                                      want.irq_raise));
          if (got.irq_clear !== want.irq_clear)
            report_mismatch($sformatf("irq_clear %b, expected %b", got.irq_clear,
                                      want.irq_clear));
          if (got.playback_on !== want.playback_on)
            report_mismatch($sformatf("playback_on %b, expected %b", got.playback_on,
                                      want.playback_on));
          if (got.capture_on !== want.capture_on)
            report_mismatch($sformatf("capture_on %b, expected %b", got.capture_on,
                                      want.capture_on));
          if (got.capture_start !== want.capture_start)
            report_mismatch($sformatf("capture_start %b, expected %b", got.capture_start,
                                      want.capture_start));
          if (got.capture_stop !== want.capture_stop)
            report_mismatch($sformatf("capture_stop %b, expected %b", got.capture_stop,
                                      want.capture_stop));
          if (got.divider !== want.divider)
            report_mismatch($sformatf("divider %0d, expected %0d", got.divider,
                                      want.divider));
          if (got.sample_count !== want.sample_count)
            report_mismatch($sformatf("sample_count %h, expected %h", got.sample_count,
                                      want.sample_count));
        end
      end
      if (in_bus.valid && in_bus.ready)
        pending_results.push_back(predict_access(in_bus.mode, in_bus.addr, in_bus.wdata));
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Ends the run when no item moves on either channel for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // Offers one item after a random gap, none while steady, and waits until it is taken.
  task automatic send_access(logic [1:0] mode, logic [2:0] addr, logic [7:0] wdata);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.mode <= mode;
    in_bus.addr <= addr;
    in_bus.wdata <= wdata;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic test_reset_reads();
    send_access(MODE_READ, ADDR_CFG_LO, 8'h00);
    send_access(MODE_READ, ADDR_INDEX, 8'hff);
    send_access(MODE_READ, ADDR_DATA, 8'h00);
    send_access(MODE_READ, ADDR_STATUS, 8'h00);
    send_access(MODE_READ, ADDR_UNUSED, 8'h00);
  endtask

  task automatic test_config_and_index();
    send_access(MODE_WRITE, ADDR_CFG_HI, 8'hff);
    send_access(MODE_READ, ADDR_CFG_HI, 8'h00);
    send_access(MODE_WRITE, ADDR_INDEX, 8'hff);
    send_access(MODE_READ, ADDR_INDEX, 8'h00);
  endtask

  task automatic test_rate_divider();
    send_access(MODE_WRITE, ADDR_INDEX, {4'h0, REG_RATE});
    send_access(MODE_WRITE, ADDR_DATA, 8'h0e);
    send_access(MODE_WRITE, ADDR_DATA, 8'h0a);
  endtask

  // Capture on with playback, playback off, then capture off with playback back on.
  task automatic test_capture_control();
    send_access(MODE_WRITE, ADDR_INDEX, {4'h0, REG_CAPTURE});
    send_access(MODE_WRITE, ADDR_DATA, 8'h03);
    send_access(MODE_WRITE, ADDR_DATA, 8'h43);
    send_access(MODE_WRITE, ADDR_DATA, 8'h83);
  endtask

  task automatic test_transfer_count();
    send_access(MODE_WRITE, ADDR_INDEX, {4'h0, REG_COUNT_LO});
    send_access(MODE_WRITE, ADDR_DATA, 8'hff);
    send_access(MODE_WRITE, ADDR_INDEX, {4'h0, REG_COUNT_HI});
    send_access(MODE_WRITE, ADDR_DATA, 8'hff);
  endtask

  task automatic test_read_only_reg();
    send_access(MODE_WRITE, ADDR_INDEX, {4'h0, REG_RDONLY});
    send_access(MODE_WRITE, ADDR_DATA, 8'h55);
    send_access(MODE_READ, ADDR_DATA, 8'h00);
  endtask

  // Interrupt with the enable off, then on, then cleared by a status write.
  task automatic test_interrupts();
    send_access(MODE_IRQ, ADDR_CFG_LO, 8'h00);
    send_access(MODE_WRITE, ADDR_INDEX, {4'h0, REG_IRQ_CTRL});
    send_access(MODE_WRITE, ADDR_DATA, 8'h02);
    send_access(MODE_IRQ, ADDR_UNUSED, 8'hff);
    send_access(MODE_WRITE, ADDR_STATUS, 8'hff);
    send_access(MODE_READ, ADDR_STATUS, 8'h00);
  endtask

  task automatic test_unused_codes();
    send_access(MODE_NOP, ADDR_UNUSED, 8'hff);
    send_access(MODE_WRITE, ADDR_UNUSED, 8'hff);
  endtask

  // The result side stops for a long stretch while items keep coming.
  task automatic test_backpressure();
    steady = 1'b1;
    long_hold = 1'b1;
    repeat (12) send_access(2'($urandom_range(0, 3)), 3'($urandom), 8'($urandom));
    steady = 1'b0;
  endtask

  // Mostly index-then-data sequences with random content, plus noise.
  task automatic test_random_traffic(int unsigned n_items);
    int unsigned sent;
    logic [7:0]  idx_byte;
    sent = 0;
    while (sent < n_items) begin
      idx_byte = 8'($urandom);
      idx_byte[3:0] = pick_reg();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          send_access(MODE_WRITE, ADDR_INDEX, idx_byte);
          send_access(MODE_WRITE, ADDR_DATA, 8'($urandom));
          sent += 2;
        end
        4, 5: begin
          send_access(MODE_WRITE, ADDR_INDEX, idx_byte);
          send_access(MODE_READ, ADDR_DATA, 8'($urandom));
          sent += 2;
        end
        6: begin
          send_access(MODE_WRITE, ADDR_STATUS, 8'($urandom));
          send_access(MODE_READ, ADDR_STATUS, 8'($urandom));
          sent += 2;
        end
        7: begin
          send_access(MODE_IRQ, 3'($urandom), 8'($urandom));
          sent += 1;
        end
        default: begin
          send_access(2'($urandom_range(0, 3)), 3'($urandom), 8'($urandom));
          sent += 1;
        end
      endcase
    end
  endtask

  // Main sequence.
  initial begin
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.mode = MODE_READ;
    in_bus.addr = ADDR_CFG_LO;
    in_bus.wdata = 8'h00;
    steady = 1'b0;
    long_hold = 1'b0;
    mismatch_count = 0;

    // Model reset state.
    cur_index = 4'h0;
    cur_trd = 1'b0;
    cur_mce = 1'b1;
    cfg_byte = 8'h00;
    stat_byte = STATUS_RESET;
    codec_regs = REGS_AT_RESET;
    play_en = 1'b0;
    cap_en = 1'b0;
    rate_div = RATE_DIVS[0];
    xfer_count = 16'h0000;

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_reset_reads();
    test_config_and_index();
    test_rate_divider();
    test_capture_control();
    test_transfer_count();
    test_read_only_reg();
    test_interrupts();
    test_unused_codes();
    test_backpressure();
    test_random_traffic(300);
    steady = 1'b1;
    test_random_traffic(250);
    steady = 1'b0;
    test_random_traffic(290);

    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/cirf_pkg.sv
rtl/cirf_in_if.sv
rtl/cirf_out_if.sv
rtl/cirf_regmem.sv
rtl/cirf_ctrl.sv
rtl/codec_indexed_register_file_top.sv
tb/codec_indexed_register_file_top_tb.sv
